// ----- src/mcc2d_pkg.sv -----
// ---------------------------------------------------------------------------
// mcc2d_pkg
// shared constants, codes and types of the multichannel convolution point
// ---------------------------------------------------------------------------
`default_nettype none

package mcc2d_pkg;

  localparam int MAX_IMAGE_SIZE = 16;
  localparam int CHANNELS       = 3;
  localparam int KERNEL_H       = 3;
  localparam int KERNEL_W       = 3;
  localparam int NUM_KERNELS    = 2;

  localparam int TAPS       = CHANNELS * KERNEL_H * KERNEL_W;
  localparam int WGT_DEPTH  = NUM_KERNELS * TAPS;
  localparam int IMG_DEPTH  = CHANNELS * MAX_IMAGE_SIZE * MAX_IMAGE_SIZE;
  localparam int WGT_AW     = $clog2(WGT_DEPTH);
  localparam int IMG_AW     = $clog2(IMG_DEPTH);
  localparam int IMG_CW     = (MAX_IMAGE_SIZE > 1) ? $clog2(MAX_IMAGE_SIZE) : 1;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int KH_W       = (KERNEL_H > 1) ? $clog2(KERNEL_H) : 1;
  localparam int KW_W       = (KERNEL_W > 1) ? $clog2(KERNEL_W) : 1;

  localparam int DATA_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ACC_W      = 48;
  localparam int OUT_W      = 40;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int COORD_W    = 8;

  localparam logic [4:0] RST_IN_WIDTH  = 5'd3;
  localparam logic [4:0] RST_IN_HEIGHT = 5'd3;
  localparam logic [1:0] RST_PAD_X     = 2'd1;
  localparam logic [1:0] RST_PAD_Y     = 2'd1;
  localparam logic [2:0] RST_STRIDE_X  = 3'd1;
  localparam logic [2:0] RST_STRIDE_Y  = 3'd1;

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ACT_WEIGHT  = 2'd0,
    ACT_SAMPLE  = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH  = 3'd0,
    REG_IN_HEIGHT = 3'd1,
    REG_PAD_X     = 3'd2,
    REG_PAD_Y     = 3'd3,
    REG_STRIDE_X  = 3'd4,
    REG_STRIDE_Y  = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic issue;
    logic finish;
    logic bad;
  } mac_ctrl_t;

  typedef struct packed {
    logic empty;
    logic out_free;
  } mac_status_t;

endpackage

`default_nettype wire

// ----- src/multichannel_conv2d_point.sv -----
// writes give no transaction; a request gives its result once every tap has been issued
// and the multiply-accumulate pipeline has drained, sooner when the last taps fall in the
// padding; a flagged request issues no taps and gives a zero result with bad_coord set
// throughput: one tap per cycle through one read port per store and one multiplier;
// the next transaction is taken only after the result has loaded into the output register
// reset: synchronous, restores configuration defaults; stores are not cleared
// ---------------------------------------------------------------------------
// multichannel_conv2d_point
// multichannel 2-d convolution, one output point per request
// ---------------------------------------------------------------------------
`default_nettype none

module multichannel_conv2d_point (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       action,
  input  wire logic [0:0]                       kernel,
  input  wire logic [1:0]                       channel,
  input  wire logic [3:0]                       row,
  input  wire logic [3:0]                       col,
  input  wire logic signed [15:0]               value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [39:0]                    conv_value,
  output logic                                  bad_coord,
  input  wire logic                             cfg_write,
  input  wire logic [mcc2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mcc2d_pkg::CFG_W-1:0]      cfg_data
);

  import mcc2d_pkg::*;

  logic              wgt_we;
  logic [WGT_AW-1:0] wgt_waddr;
  logic [WGT_AW-1:0] wgt_raddr;
  logic [DATA_W-1:0] wgt_rdata;
  logic              img_we;
  logic [IMG_AW-1:0] img_waddr;
  logic [IMG_AW-1:0] img_raddr;
  logic [DATA_W-1:0] img_rdata;
  mac_ctrl_t         mac_ctrl;
  mac_status_t       mac_status;

  mcc2d_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .kernel     (kernel),
    .channel    (channel),
    .row        (row),
    .col        (col),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .wgt_we     (wgt_we),
    .wgt_waddr  (wgt_waddr),
    .wgt_raddr  (wgt_raddr),
    .img_we     (img_we),
    .img_waddr  (img_waddr),
    .img_raddr  (img_raddr),
    .mac_ctrl   (mac_ctrl),
    .mac_status (mac_status)
  );

  mcc2d_ram #(
    .DEPTH (WGT_DEPTH),
    .WIDTH (DATA_W)
  ) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (wgt_waddr),
    .wdata (value),
    .raddr (wgt_raddr),
    .rdata (wgt_rdata)
  );

  mcc2d_ram #(
    .DEPTH (IMG_DEPTH),
    .WIDTH (DATA_W)
  ) u_img_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (value),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  mcc2d_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (mac_ctrl),
    .status     (mac_status),
    .wgt_data   ($signed(wgt_rdata)),
    .img_data   ($signed(img_rdata)),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .conv_value (conv_value),
    .bad_coord  (bad_coord)
  );

endmodule

`default_nettype wire

// ----- src/mcc2d_ram.sv -----
// ---------------------------------------------------------------------------
// mcc2d_ram
// generic single write port, single read port ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module mcc2d_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/mcc2d_mac.sv -----
// ---------------------------------------------------------------------------
// mcc2d_mac
// registered multiply and accumulate, combinational saturation and output register
// ---------------------------------------------------------------------------
`default_nettype none

module mcc2d_mac (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire mcc2d_pkg::mac_ctrl_t     ctrl,
  output mcc2d_pkg::mac_status_t        status,
  input  wire logic signed [15:0]       wgt_data,
  input  wire logic signed [15:0]       img_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [39:0]            conv_value,
  output logic                          bad_coord
);

  import mcc2d_pkg::*;

  logic                     v1;
  logic                     v2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [OUT_W-1:0]  sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctrl.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      prod <= wgt_data * img_data;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  always_comb begin
    if (acc > SAT_MAX) begin
      sat = SAT_MAX[OUT_W-1:0];
    end else if (acc < SAT_MIN) begin
      sat = SAT_MIN[OUT_W-1:0];
    end else begin
      sat = acc[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      conv_value <= ctrl.bad ? '0 : sat;
      bad_coord  <= ctrl.bad;
    end
  end

  always_comb begin
    status.empty    = !v1 && !v2;
    status.out_free = !out_valid || !out_stall;
  end

  // result only loaded once the pipeline has drained
  a_finish_drained: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |-> (!v1 && !v2))
    else $error("result loaded with products in flight");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (ctrl.clear && !v2) |=> (acc == '0))
    else $error("accumulator not cleared");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_coord) |-> (conv_value == '0))
    else $error("flagged result not zero");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !ctrl.finish)
    else $error("pending transaction overwritten");

endmodule

`default_nettype wire

// ----- src/mcc2d_ctrl.sv -----
// ---------------------------------------------------------------------------
// mcc2d_ctrl
// configuration registers, store writes and the tap sequencer
// ---------------------------------------------------------------------------
`default_nettype none

module mcc2d_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       action,
  input  wire logic [0:0]                       kernel,
  input  wire logic [1:0]                       channel,
  input  wire logic [3:0]                       row,
  input  wire logic [3:0]                       col,
  input  wire logic                             cfg_write,
  input  wire logic [mcc2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mcc2d_pkg::CFG_W-1:0]      cfg_data,
  output logic                                  wgt_we,
  output logic [mcc2d_pkg::WGT_AW-1:0]          wgt_waddr,
  output logic [mcc2d_pkg::WGT_AW-1:0]          wgt_raddr,
  output logic                                  img_we,
  output logic [mcc2d_pkg::IMG_AW-1:0]          img_waddr,
  output logic [mcc2d_pkg::IMG_AW-1:0]          img_raddr,
  output mcc2d_pkg::mac_ctrl_t                  mac_ctrl,
  input  wire mcc2d_pkg::mac_status_t           mac_status
);

  import mcc2d_pkg::*;

  state_t state;
  state_t state_next;

  logic [4:0] in_width;
  logic [4:0] in_height;
  logic [1:0] pad_x;
  logic [1:0] pad_y;
  logic [2:0] stride_x;
  logic [2:0] stride_y;

  logic [4:0]                wc;
  logic [4:0]                hc;
  logic [2:0]                sx;
  logic [2:0]                sy;
  logic signed [COORD_W-1:0] num_x;
  logic signed [COORD_W-1:0] num_y;
  logic [COORD_W-2:0]        col_mul;
  logic [COORD_W-2:0]        row_mul;
  logic                      req_bad;
  logic                      accept;

  logic                      bad;
  logic signed [COORD_W-1:0] base_x;
  logic signed [COORD_W-1:0] base_y;
  logic [CH_W-1:0]           cnt_c;
  logic [KH_W-1:0]           cnt_q;
  logic [KW_W-1:0]           cnt_p;
  logic signed [COORD_W-1:0] tap_x;
  logic signed [COORD_W-1:0] tap_y;
  logic                      tap_ok;
  logic                      last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_width  <= RST_IN_WIDTH;
      in_height <= RST_IN_HEIGHT;
      pad_x     <= RST_PAD_X;
      pad_y     <= RST_PAD_Y;
      stride_x  <= RST_STRIDE_X;
      stride_y  <= RST_STRIDE_Y;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IN_WIDTH:  in_width  <= cfg_data;
        REG_IN_HEIGHT: in_height <= cfg_data;
        REG_PAD_X:     pad_x     <= cfg_data[1:0];
        REG_PAD_Y:     pad_y     <= cfg_data[1:0];
        REG_STRIDE_X:  stride_x  <= cfg_data[2:0];
        REG_STRIDE_Y:  stride_y  <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // geometry of the request
  always_comb begin
    wc      = (in_width > 5'(MAX_IMAGE_SIZE)) ? 5'(MAX_IMAGE_SIZE) : in_width;
    hc      = (in_height > 5'(MAX_IMAGE_SIZE)) ? 5'(MAX_IMAGE_SIZE) : in_height;
    sx      = (stride_x == 3'd0) ? 3'd1 : stride_x;
    sy      = (stride_y == 3'd0) ? 3'd1 : stride_y;
    num_x   = $signed({3'b0, wc}) + $signed({5'b0, pad_x, 1'b0})
              - COORD_W'(KERNEL_W);
    num_y   = $signed({3'b0, hc}) + $signed({5'b0, pad_y, 1'b0})
              - COORD_W'(KERNEL_H);
    col_mul = (COORD_W-1)'(col) * (COORD_W-1)'(sx);
    row_mul = (COORD_W-1)'(row) * (COORD_W-1)'(sy);
    req_bad = (32'(kernel) >= NUM_KERNELS) || num_x[COORD_W-1] || num_y[COORD_W-1]
              || ($signed({1'b0, col_mul}) > num_x)
              || ($signed({1'b0, row_mul}) > num_y);
  end

  // store writes
  always_comb begin
    accept    = in_valid && (state == ST_IDLE);
    in_stall  = (state != ST_IDLE);
    wgt_we    = accept && (action == ACT_WEIGHT) && (32'(kernel) < NUM_KERNELS)
                && (32'(channel) < CHANNELS) && (32'(row) < KERNEL_H)
                && (32'(col) < KERNEL_W);
    wgt_waddr = WGT_AW'(kernel) * WGT_AW'(TAPS)
                + WGT_AW'(channel) * WGT_AW'(KERNEL_H * KERNEL_W)
                + WGT_AW'(row) * WGT_AW'(KERNEL_W) + WGT_AW'(col);
    img_we    = accept && (action == ACT_SAMPLE) && (32'(channel) < CHANNELS)
                && (32'(row) < MAX_IMAGE_SIZE) && (32'(col) < MAX_IMAGE_SIZE);
    img_waddr = IMG_AW'(channel) * IMG_AW'(MAX_IMAGE_SIZE * MAX_IMAGE_SIZE)
                + IMG_AW'(row) * IMG_AW'(MAX_IMAGE_SIZE) + IMG_AW'(col);
  end

  // current tap
  always_comb begin
    tap_x     = base_x + $signed(COORD_W'(cnt_p));
    tap_y     = base_y + $signed(COORD_W'(cnt_q));
    tap_ok    = !tap_x[COORD_W-1] && !tap_y[COORD_W-1]
                && (tap_x < $signed({3'b0, wc})) && (tap_y < $signed({3'b0, hc}));
    img_raddr = IMG_AW'(cnt_c) * IMG_AW'(MAX_IMAGE_SIZE * MAX_IMAGE_SIZE)
                + IMG_AW'(tap_y[IMG_CW-1:0]) * IMG_AW'(MAX_IMAGE_SIZE)
                + IMG_AW'(tap_x[IMG_CW-1:0]);
    last      = (cnt_c == CH_W'(CHANNELS - 1)) && (cnt_q == KH_W'(KERNEL_H - 1))
                && (cnt_p == KW_W'(KERNEL_W - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    mac_ctrl.clear  = 1'b0;
    mac_ctrl.issue  = 1'b0;
    mac_ctrl.finish = 1'b0;
    mac_ctrl.bad    = bad;
    case (state)
      ST_IDLE: begin
        if (accept && (action == ACT_COMPUTE)) begin
          state_next     = req_bad ? ST_DONE : ST_RUN;
          mac_ctrl.clear = !req_bad;
        end
      end
      ST_RUN: begin
        mac_ctrl.issue = tap_ok;
        if (last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_status.empty) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        mac_ctrl.finish = mac_status.out_free;
        if (mac_status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && (action == ACT_COMPUTE)) begin
      bad       <= req_bad;
      base_x    <= $signed({1'b0, col_mul}) - $signed(COORD_W'(pad_x));
      base_y    <= $signed({1'b0, row_mul}) - $signed(COORD_W'(pad_y));
      wgt_raddr <= WGT_AW'(kernel) * WGT_AW'(TAPS);
      cnt_c     <= '0;
      cnt_q     <= '0;
      cnt_p     <= '0;
    end else if (state == ST_RUN) begin
      wgt_raddr <= wgt_raddr + WGT_AW'(1);
      if (cnt_p == KW_W'(KERNEL_W - 1)) begin
        cnt_p <= '0;
        if (cnt_q == KH_W'(KERNEL_H - 1)) begin
          cnt_q <= '0;
          cnt_c <= cnt_c + CH_W'(1);
        end else begin
          cnt_q <= cnt_q + KH_W'(1);
        end
      end else begin
        cnt_p <= cnt_p + KW_W'(1);
      end
    end
  end

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !(wgt_we || img_we))
    else $error("store written during a computation");

  a_issue_run: assert property (@(posedge clk) disable iff (rst)
    mac_ctrl.issue |-> (state == ST_RUN))
    else $error("tap issued outside the run phase");

  a_wgt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (32'(wgt_raddr) < WGT_DEPTH))
    else $error("weight read address out of range");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    mac_ctrl.finish |=> (state == ST_IDLE))
    else $error("sequencer did not return to idle");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// checks the multichannel convolution point against a cycle-free predictor:
// weight and sample writes update a shadow copy of both stores, each output
// request is worked out from that copy and the live configuration, and every
// result transaction is compared field by field in arrival order
// ---------------------------------------------------------------------------

module tb;
  import mcc2d_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int CHOKE_CYCLES = 400;
  localparam longint SUM_MAX = (longint'(1) <<< 39) - 1;
  localparam longint SUM_MIN = -(longint'(1) <<< 39);

  typedef struct packed {
    logic [1:0]         act;
    logic [0:0]         kern;
    logic [1:0]         chan;
    logic [3:0]         pos_row;
    logic [3:0]         pos_col;
    logic signed [15:0] word;
  } stim_t;

  typedef struct packed {
    logic signed [39:0] sum;
    logic               flag;
  } point_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = '0;
  logic [0:0] kernel = '0;
  logic [1:0] channel = '0;
  logic [3:0] row = '0;
  logic [3:0] col = '0;
  logic signed [15:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [39:0] conv_value;
  logic bad_coord;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // shadow of the block
  logic signed [15:0] kern_mem [WGT_DEPTH];
  logic signed [15:0] img_mem [IMG_DEPTH];
  logic [4:0] cfg_width = RST_IN_WIDTH;
  logic [4:0] cfg_height = RST_IN_HEIGHT;
  logic [1:0] cfg_pad_x = RST_PAD_X;
  logic [1:0] cfg_pad_y = RST_PAD_Y;
  logic [2:0] cfg_stride_x = RST_STRIDE_X;
  logic [2:0] cfg_stride_y = RST_STRIDE_Y;
  point_t expected_points [$];

  // stimulus bookkeeping
  stim_t pending_items [$];
  stim_t tx_item;
  bit wgt_set [WGT_DEPTH];
  bit img_set [IMG_DEPTH];
  int counted = 0;
  int fill_mode = 0;
  int errors = 0;
  int results_seen = 0;
  int tx_wait = 0;
  int tx_calm = 0;
  int rx_wait = 0;
  int rx_calm = 0;
  int choke_asked = 0;
  int choke_done = 0;
  int choke_left = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  multichannel_conv2d_point DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .kernel     (kernel),
    .channel    (channel),
    .row        (row),
    .col        (col),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .conv_value (conv_value),
    .bad_coord  (bad_coord),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int eff_size(input logic [4:0] raw);
    return (raw > MAX_IMAGE_SIZE) ? MAX_IMAGE_SIZE : int'(raw);
  endfunction

  function automatic int eff_stride(input logic [2:0] raw);
    return (raw == 3'd0) ? 1 : int'(raw);
  endfunction

  function automatic int axis_len(input int size, input int pad, input int span, input int step);
    int num;
    num = size + 2 * pad - span;
    return (num < 0) ? 0 : num / step + 1;
  endfunction

  function automatic point_t conv_point_of(input logic [0:0] k, input logic [3:0] r,
                                           input logic [3:0] cl);
    point_t res;
    longint acc;
    int w, h, sx, sy, y, x;
    w = eff_size(cfg_width);
    h = eff_size(cfg_height);
    sx = eff_stride(cfg_stride_x);
    sy = eff_stride(cfg_stride_y);
    res.sum = '0;
    res.flag = 1'b0;
    acc = 0;
    if (int'(k) >= NUM_KERNELS || int'(cl) >= axis_len(w, int'(cfg_pad_x), KERNEL_W, sx) ||
        int'(r) >= axis_len(h, int'(cfg_pad_y), KERNEL_H, sy)) begin
      res.flag = 1'b1;
      return res;
    end
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int q = 0; q < KERNEL_H; q++) begin
        for (int p = 0; p < KERNEL_W; p++) begin
          y = sy * int'(r) + q - int'(cfg_pad_y);
          x = sx * int'(cl) + p - int'(cfg_pad_x);
          if (y >= 0 && y < h && x >= 0 && x < w) begin
            acc += longint'(kern_mem[((int'(k) * CHANNELS + ch) * KERNEL_H + q) * KERNEL_W + p]) *
                   longint'(img_mem[(ch * MAX_IMAGE_SIZE + y) * MAX_IMAGE_SIZE + x]);
          end
        end
      end
    end
    if (acc > SUM_MAX) acc = SUM_MAX;
    if (acc < SUM_MIN) acc = SUM_MIN;
    res.sum = acc[39:0];
    return res;
  endfunction

  function automatic void absorb_item();
    case (action)
      ACT_WEIGHT: begin
        if (int'(kernel) < NUM_KERNELS && int'(channel) < CHANNELS &&
            int'(row) < KERNEL_H && int'(col) < KERNEL_W) begin
          kern_mem[((int'(kernel) * CHANNELS + int'(channel)) * KERNEL_H + int'(row)) * KERNEL_W
                   + int'(col)] = value;
        end
      end
      ACT_SAMPLE: begin
        if (int'(channel) < CHANNELS) begin
          img_mem[(int'(channel) * MAX_IMAGE_SIZE + int'(row)) * MAX_IMAGE_SIZE + int'(col)] = value;
        end
      end
      ACT_COMPUTE: begin
        expected_points.push_back(conv_point_of(kernel, row, col));
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void flag_fault(input string what);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, what);
  endfunction

  function automatic int idle_draw(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // shadow update and result check
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
      cfg_width = RST_IN_WIDTH;
      cfg_height = RST_IN_HEIGHT;
      cfg_pad_x = RST_PAD_X;
      cfg_pad_y = RST_PAD_Y;
      cfg_stride_x = RST_STRIDE_X;
      cfg_stride_y = RST_STRIDE_Y;
    end else begin
      in_taken <= in_valid && !in_stall;
      out_taken <= out_valid && !out_stall;
      if (cfg_write) begin
        case (cfg_index)
          REG_IN_WIDTH:  cfg_width = cfg_data[4:0];
          REG_IN_HEIGHT: cfg_height = cfg_data[4:0];
          REG_PAD_X:     cfg_pad_x = cfg_data[1:0];
          REG_PAD_Y:     cfg_pad_y = cfg_data[1:0];
          REG_STRIDE_X:  cfg_stride_x = cfg_data[2:0];
          REG_STRIDE_Y:  cfg_stride_y = cfg_data[2:0];
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) absorb_item();
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_points.size() == 0) begin
          flag_fault($sformatf("result %0d with nothing outstanding: value %0d flag %0b",
                               results_seen, conv_value, bad_coord));
        end else begin
          point_t want;
          want = expected_points.pop_front();
          if (conv_value !== want.sum || bad_coord !== want.flag) begin
            flag_fault($sformatf("result %0d: expected value %0d flag %0b, got value %0d flag %0b",
                                 results_seen, want.sum, want.flag, conv_value, bad_coord));
          end
        end
      end
    end
  end

  // sender
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
    end else if (tx_wait > 0) begin
      tx_wait--;
      in_valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      tx_item = pending_items.pop_front();
      action <= tx_item.act;
      kernel <= tx_item.kern;
      channel <= tx_item.chan;
      row <= tx_item.pos_row;
      col <= tx_item.pos_col;
      value <= tx_item.word;
      in_valid <= 1'b1;
      tx_wait = idle_draw(tx_calm);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // long hold-off of the result side
  always @(posedge clk) begin
    if (choke_left > 0) begin
      choke_left <= choke_left - 1;
    end else if (choke_asked != choke_done) begin
      choke_done <= choke_asked;
      choke_left <= CHOKE_CYCLES;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_taken) rx_wait = idle_draw(rx_calm);
      out_stall <= (choke_left > 0) || (rx_wait > 0);
      if (rx_wait > 0) rx_wait--;
    end
  end

  function automatic logic signed [15:0] fill_word();
    case (fill_mode)
      1: return 16'sh8000;
      2: return 16'sh7fff;
      3: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_item(input logic [1:0] a, input logic [0:0] k, input logic [1:0] ch,
                            input logic [3:0] r, input logic [3:0] cl,
                            input logic signed [15:0] v);
    stim_t s;
    s = '{a, k, ch, r, cl, v};
    pending_items.push_back(s);
    if (a == ACT_WEIGHT && int'(ch) < CHANNELS && int'(r) < KERNEL_H && int'(cl) < KERNEL_W) begin
      wgt_set[((int'(k) * CHANNELS + int'(ch)) * KERNEL_H + int'(r)) * KERNEL_W + int'(cl)] = 1'b1;
      counted++;
    end else if (a == ACT_SAMPLE && int'(ch) < CHANNELS) begin
      img_set[(int'(ch) * MAX_IMAGE_SIZE + int'(r)) * MAX_IMAGE_SIZE + int'(cl)] = 1'b1;
      counted++;
    end else if (a == ACT_COMPUTE) begin
      counted++;
    end
  endtask

  // for a point inside the output, writes every tap the window still lacks; then asks for the point
  task automatic ask_point(input logic [0:0] k, input int r, input int cl);
    int w, h, sx, sy, y, x, wi, ii;
    w = eff_size(cfg_width);
    h = eff_size(cfg_height);
    sx = eff_stride(cfg_stride_x);
    sy = eff_stride(cfg_stride_y);
    if (r < axis_len(h, int'(cfg_pad_y), KERNEL_H, sy) &&
        cl < axis_len(w, int'(cfg_pad_x), KERNEL_W, sx)) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        for (int q = 0; q < KERNEL_H; q++) begin
          for (int p = 0; p < KERNEL_W; p++) begin
            y = sy * r + q - int'(cfg_pad_y);
            x = sx * cl + p - int'(cfg_pad_x);
            if (y >= 0 && y < h && x >= 0 && x < w) begin
              wi = ((int'(k) * CHANNELS + ch) * KERNEL_H + q) * KERNEL_W + p;
              ii = (ch * MAX_IMAGE_SIZE + y) * MAX_IMAGE_SIZE + x;
              if (!wgt_set[wi]) queue_item(ACT_WEIGHT, k, 2'(ch), 4'(q), 4'(p), fill_word());
              if (!img_set[ii]) queue_item(ACT_SAMPLE, 1'($urandom), 2'(ch), 4'(y), 4'(x),
                                           fill_word());
            end
          end
        end
      end
    end
    queue_item(ACT_COMPUTE, k, 2'($urandom), 4'(r), 4'(cl), 16'($urandom));
  endtask

  task automatic random_phase(input int n);
    int stop, pick, ox, oy, r, cl;
    stop = counted + n;
    while (counted < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        ox = axis_len(eff_size(cfg_width), int'(cfg_pad_x), KERNEL_W, eff_stride(cfg_stride_x));
        oy = axis_len(eff_size(cfg_height), int'(cfg_pad_y), KERNEL_H, eff_stride(cfg_stride_y));
        if (ox > 16) ox = 16;
        if (oy > 16) oy = 16;
        if (ox > 0 && oy > 0 && $urandom_range(0, 3) != 0) begin
          r = $urandom_range(0, oy - 1);
          cl = $urandom_range(0, ox - 1);
        end else begin
          r = $urandom_range(0, 15);
          cl = $urandom_range(0, 15);
        end
        fill_mode = ($urandom_range(0, 9) == 0) ? 3 : 0;
        ask_point(1'($urandom), r, cl);
      end else if (pick < 82) begin
        queue_item(ACT_WEIGHT, 1'($urandom), 2'($urandom_range(0, CHANNELS - 1)),
                   4'($urandom_range(0, KERNEL_H - 1)), 4'($urandom_range(0, KERNEL_W - 1)),
                   16'($urandom));
      end else if (pick < 92) begin
        queue_item(ACT_SAMPLE, 1'($urandom), 2'($urandom_range(0, CHANNELS - 1)),
                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 16'($urandom));
      end else if (pick < 97) begin
        queue_item(2'($urandom_range(0, 1)), 1'($urandom), 2'($urandom_range(0, 3)),
                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 16'($urandom));
      end else begin
        queue_item(ACT_UNUSED, 1'($urandom), 2'($urandom), 4'($urandom), 4'($urandom),
                   16'($urandom));
      end
    end
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_config(input int w, input int h, input int px, input int py,
                            input int sx, input int sy);
    write_reg(REG_IN_WIDTH, w);
    write_reg(REG_IN_HEIGHT, h);
    write_reg(REG_PAD_X, px);
    write_reg(REG_PAD_Y, py);
    write_reg(REG_STRIDE_X, sx);
    write_reg(REG_STRIDE_Y, sy);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset configuration: ignored transactions, extreme fills, overwrite, bad points
    queue_item(ACT_UNUSED, 1, 3, 15, 15, 16'sh7fff);
    queue_item(ACT_WEIGHT, 1, 3, 0, 0, 16'sh1234);
    queue_item(ACT_WEIGHT, 0, 0, 3, 0, 16'sh0f0f);
    queue_item(ACT_WEIGHT, 0, 0, 0, 15, 16'sh5a5a);
    queue_item(ACT_SAMPLE, 1, 3, 15, 15, 16'sh8000);
    fill_mode = 1;
    ask_point(0, 0, 0);
    fill_mode = 2;
    ask_point(1, 2, 2);
    ask_point(0, 1, 1);
    queue_item(ACT_SAMPLE, 0, 0, 1, 1, 16'sh0001);
    ask_point(0, 1, 1);
    ask_point(1, 0, 3);
    ask_point(0, 15, 15);
    ask_point(1, 3, 0);
    drain();

    set_config(16, 16, 0, 0, 1, 1);
    random_phase(150);
    drain();
    set_config(1, 1, 2, 2, 4, 4);
    choke_asked++;
    random_phase(100);
    drain();
    set_config(31, 31, 3, 3, 7, 7);
    random_phase(140);
    drain();
    set_config(0, 5, 1, 3, 0, 2);
    random_phase(100);
    drain();
    set_config(4, 16, 2, 0, 2, 3);
    choke_asked++;
    random_phase(140);
    drain();
    set_config(5, 7, 2, 1, 3, 1);
    random_phase(120);
    for (int i = 0; i < 6; i++) begin
      drain();
      set_config($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 3),
                 $urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 7));
      if (i == 3) choke_asked++;
      random_phase(135);
    end
    drain();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
